[design/brf_pkg.sv]
// Shared types and constants for the bordered line run finder.
`default_nettype none
package brf_pkg;

  localparam int SENSOR_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int MAX_RESULTS     = 16;
  localparam int IN_W            = 32;
  localparam int START_W         = 5;
  localparam int END_W           = 6;
  localparam int CFG_W           = 5;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_GAPS  = 2'd2;

  localparam logic [4:0] BORDER_MIN_RST = 5'd2;
  localparam logic [4:0] LINE_MIN_RST   = 5'd3;
  localparam logic       FILL_GAPS_RST  = 1'b0;

  typedef struct packed {
    logic [4:0] border_min;
    logic [4:0] line_min;
    logic       fill_gaps;
  } cfg_t;

  typedef struct packed {
    logic               valid_res;
    logic [START_W-1:0] line_start;
    logic [END_W-1:0]   line_end;
    logic               last;
  } res_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SCAN,
    FR_DONE
  } front_state_t;

endpackage
`default_nettype wire

[design/brf_front.sv]
// Front end: takes a word, fills gaps if set, scans it one bit per cycle unless q_full.
`default_nettype none
module brf_front #(
  parameter int SENSOR_BITS = brf_pkg::SENSOR_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire brf_pkg::cfg_t               cfg,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [brf_pkg::IN_W-1:0]    in_sample_bits,
  output logic                             push,
  output brf_pkg::res_t                    push_data,
  input  wire logic                        q_full
);

  localparam int CW    = $clog2(SENSOR_BITS + 1);
  localparam int LW    = (CW > 5) ? CW : 5;
  localparam int CNT_W = $clog2(brf_pkg::MAX_RESULTS + 1);

  brf_pkg::front_state_t state_r, state_nxt;

  logic [SENSOR_BITS-1:0] sh_r;
  logic [CW-1:0]          pos_r;
  logic                   prev_r;
  logic [CW-1:0]          zstart_r;
  logic [CW-1:0]          rstart_r;
  logic                   pend_v_r;
  logic                   pend_ok_r;
  logic [CW-1:0]          pend_s_r;
  logic [CW-1:0]          pend_e_r;
  logic                   held_v_r;
  logic [CW-1:0]          held_s_r;
  logic [CW-1:0]          held_e_r;
  logic [CNT_W-1:0]       cnt_r;

  logic [SENSOR_BITS-1:0] d_in;
  logic [SENSOR_BITS-1:0] d_fill;
  logic                   accept;
  logic                   step;
  logic                   resolve;
  logic                   final_push;
  logic                   b;
  logic                   rise;
  logic                   fall;
  logic [CW-1:0]          right_len;
  logic                   qual;
  logic                   take;
  logic                   run_ok;

  assign d_in   = SENSOR_BITS'(in_sample_bits);
  assign d_fill = cfg.fill_gaps ? (d_in | ((d_in >> 1) & (d_in << 1))) : d_in;

  assign accept     = (state_r == brf_pkg::FR_IDLE) && in_valid;
  assign step       = (state_r == brf_pkg::FR_SCAN) && !q_full;
  assign resolve    = (state_r == brf_pkg::FR_DONE) && !q_full && pend_v_r;
  assign final_push = (state_r == brf_pkg::FR_DONE) && !q_full && !pend_v_r;

  assign b    = sh_r[0];
  assign rise = step && b && !prev_r;
  assign fall = step && !b && prev_r;

  // right border: up to the next one, or to the top edge when the scan is done
  assign right_len = rise ? (pos_r - pend_e_r) : (CW'(SENSOR_BITS) - pend_e_r);
  assign qual = (rise || resolve) && pend_v_r && pend_ok_r &&
                (LW'(right_len) > LW'(cfg.border_min));
  assign take = qual && (cnt_r < CNT_W'(brf_pkg::MAX_RESULTS));

  assign run_ok = (rstart_r != '0) &&
                  (LW'(pos_r - rstart_r) > LW'(cfg.line_min)) &&
                  (LW'(rstart_r - zstart_r) > LW'(cfg.border_min));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brf_pkg::FR_IDLE: begin
        if (in_valid) state_nxt = brf_pkg::FR_SCAN;
      end
      brf_pkg::FR_SCAN: begin
        if (step && (pos_r == CW'(SENSOR_BITS - 1))) state_nxt = brf_pkg::FR_DONE;
      end
      brf_pkg::FR_DONE: begin
        if (final_push) state_nxt = brf_pkg::FR_IDLE;
      end
      default: state_nxt = brf_pkg::FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    push      = 1'b0;
    push_data = '0;
    unique case (state_r)
      brf_pkg::FR_IDLE: begin
        in_stall = 1'b0;
      end
      brf_pkg::FR_SCAN, brf_pkg::FR_DONE: begin
        if (take && held_v_r) begin
          push                 = 1'b1;
          push_data.valid_res  = 1'b1;
          push_data.line_start = brf_pkg::START_W'(held_s_r);
          push_data.line_end   = brf_pkg::END_W'(held_e_r);
          push_data.last       = 1'b0;
        end else if (final_push) begin
          push                 = 1'b1;
          push_data.valid_res  = held_v_r;
          push_data.line_start = held_v_r ? brf_pkg::START_W'(held_s_r) : '0;
          push_data.line_end   = held_v_r ? brf_pkg::END_W'(held_e_r) : '0;
          push_data.last       = 1'b1;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= brf_pkg::FR_IDLE;
      pend_v_r <= 1'b0;
      held_v_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        pend_v_r <= 1'b0;
        held_v_r <= 1'b0;
        cnt_r    <= '0;
      end else begin
        if (rise || resolve) pend_v_r <= 1'b0;
        if (fall) pend_v_r <= 1'b1;
        if (take) begin
          held_v_r <= 1'b1;
          cnt_r    <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sh_r     <= d_fill;
      pos_r    <= '0;
      prev_r   <= 1'b0;
      zstart_r <= '0;
      rstart_r <= '0;
    end else if (step) begin
      sh_r   <= sh_r >> 1;
      pos_r  <= pos_r + 1'b1;
      prev_r <= b;
      if (rise) rstart_r <= pos_r;
      if (fall) begin
        zstart_r  <= pos_r;
        pend_s_r  <= rstart_r;
        pend_e_r  <= pos_r;
        pend_ok_r <= run_ok;
      end
    end
    if (take) begin
      held_s_r <= pend_s_r;
      held_e_r <= pend_e_r;
    end
  end

endmodule
`default_nettype wire

[design/brf_queue.sv]
// Short result queue between the scanning front end and the output stage.
`default_nettype none
module brf_queue #(
  parameter int DEPTH = brf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire brf_pkg::res_t push_data,
  output logic               full,
  input  wire logic          pop,
  output brf_pkg::res_t      pop_data,
  output logic               empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  brf_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [NW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == NW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

[design/brf_back.sv]
// Back end: drains the queue into the registered result channel.
`default_nettype none
module brf_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire brf_pkg::res_t                q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_valid_res,
  output logic [brf_pkg::START_W-1:0]       out_line_start,
  output logic [brf_pkg::END_W-1:0]         out_line_end,
  output logic                              out_last
);

  logic          out_valid_r;
  brf_pkg::res_t out_data_r;

  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_data_r <= q_data;
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = out_data_r.valid_res;
  assign out_line_start = out_data_r.line_start;
  assign out_line_end   = out_data_r.line_end;
  assign out_last       = out_data_r.last;

endmodule
`default_nettype wire

[design/bordered_line_run_finder.sv]
// Scan: a word is scanned one bit per cycle while the result queue is not full, then flushed;
//   a line still pending at the top edge is resolved before the last result is pushed.
// Words: a new word is taken only in FR_IDLE, after the last result of the word before is pushed;
//   the bit-serial scan sets the rate of words, and a full result queue stalls it further.
// Reset: border_min = 2, line_min = 3, fill_gaps = 0; queue and output stage empty.
`default_nettype none
module bordered_line_run_finder #(
  parameter int SENSOR_BITS = brf_pkg::SENSOR_BITS_DEF,
  parameter int QUEUE_DEPTH = brf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [brf_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [brf_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [brf_pkg::IN_W-1:0]      in_sample_bits,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_valid_res,
  output logic [brf_pkg::START_W-1:0]        out_line_start,
  output logic [brf_pkg::END_W-1:0]          out_line_end,
  output logic                               out_last
);

  brf_pkg::cfg_t cfg_r;
  logic          push;
  brf_pkg::res_t push_data;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  brf_pkg::res_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.border_min <= brf_pkg::BORDER_MIN_RST;
      cfg_r.line_min   <= brf_pkg::LINE_MIN_RST;
      cfg_r.fill_gaps  <= brf_pkg::FILL_GAPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        brf_pkg::CFG_BORDER_MIN: cfg_r.border_min <= cfg_data[4:0];
        brf_pkg::CFG_LINE_MIN:   cfg_r.line_min   <= cfg_data[4:0];
        brf_pkg::CFG_FILL_GAPS:  cfg_r.fill_gaps  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  brf_front #(
    .SENSOR_BITS(SENSOR_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_bits(in_sample_bits),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  brf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_data),
    .empty    (q_empty)
  );

  brf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_valid_res (out_valid_res),
    .out_line_start(out_line_start),
    .out_line_end  (out_line_end),
    .out_last      (out_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("result pushed into a full queue");

  a_null_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |-> out_last)
    else $error("empty result not marked last");

  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res) |-> ({1'b0, out_line_start} < out_line_end))
    else $error("line end not above line start");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("front end took a word without going busy");

endmodule
`default_nettype wire
